/* rtl/tsf_pkg.sv */
// Shared types and codes for the trace span folder.
package tsf_pkg;

   localparam int TICK_W  = 63;
   localparam int TAG_W   = 32;
   localparam int DEPTH_W = 16;
   localparam int ROW_W   = 5;
   localparam int SLOT_W  = 10;

   typedef logic [2:0] mode_type;
   typedef logic [1:0] kind_type;

   localparam mode_type MODE_BEGIN        = 3'd0;
   localparam mode_type MODE_END          = 3'd1;
   localparam mode_type MODE_FRAME        = 3'd2;
   localparam mode_type MODE_CLEAR_ALL    = 3'd3;
   localparam mode_type MODE_RESET_STACKS = 3'd4;

   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_SPAN  = 2'd1;
   localparam kind_type KIND_FRAME = 2'd2;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // one stack entry: begin tick and zone id
   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [TAG_W-1:0]  tag;
   } stack_entry_type;

   // fold-stage results held until the stack read returns
   typedef struct packed {
      kind_type           kind;
      logic [2:0]         thread;
      logic [TICK_W-1:0]  tick;
      logic [TAG_W-1:0]   tag;
      logic [ROW_W-1:0]   row;
      logic [SLOT_W-1:0]  slot;
      logic [ROW_W-1:0]   max_row;
      logic [DEPTH_W-1:0] open_depth;
      logic [TICK_W-1:0]  first_tick;
      logic [TICK_W-1:0]  newest_tick;
   } pend_type;

endpackage

/* rtl/tsf_if.sv */
// Event and record channel interfaces of the trace span folder.
interface tsf_req_if
   import tsf_pkg::*;
;
   logic              valid;
   logic              ready;
   mode_type          mode;
   logic [2:0]        thread;
   logic [TICK_W-1:0] tick;
   logic [TAG_W-1:0]  tag;

   modport source (output valid, mode, thread, tick, tag, input ready);
   modport sink (input valid, mode, thread, tick, tag, output ready);
endinterface

interface tsf_rsp_if
   import tsf_pkg::*;
;
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [2:0]         out_thread;
   logic [TICK_W-1:0]  start_tick;
   logic [TICK_W-1:0]  end_tick;
   logic [TAG_W-1:0]   record_tag;
   logic [ROW_W-1:0]   nesting_row;
   logic [SLOT_W-1:0]  slot;
   logic [ROW_W-1:0]   thread_max_row;
   logic [DEPTH_W-1:0] open_depth;
   logic [TICK_W-1:0]  first_tick;
   logic [TICK_W-1:0]  newest_tick;

   modport source (output valid, kind, out_thread, start_tick, end_tick, record_tag,
                   nesting_row, slot, thread_max_row, open_depth, first_tick,
                   newest_tick, input ready);
   modport sink (input valid, kind, out_thread, start_tick, end_tick, record_tag,
                 nesting_row, slot, thread_max_row, open_depth, first_tick,
                 newest_tick, output ready);
endinterface

/* rtl/tsf_stack_ram.sv */
// Open-zone stack memory: one write port, one registered read port.
module tsf_stack_ram
   import tsf_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  stack_entry_type wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output stack_entry_type rd_data
);

   stack_entry_type mem [DEPTH];
   stack_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/trace_span_folder_top.sv */
// Top level of the trace span folder: per-thread zone stacks folded into span records.
//
//   channel   dir  handshake          payload
//   req_bus   in   valid/ready        mode, thread, tick, tag
//   rsp_bus   out  valid/ready        kind, out_thread, ticks, tag, row, slot, stats
//
// Each event passes through two states: idle, where thread state is updated and the stack
// read is issued, and fetch, where the registered stack memory returns the entry.
// A new event is taken in the idle state when the result register is free or being drained.
// Reset is synchronous; thread state clears at once, stack entries are undefined
// until a begin writes them. A stalled result holds its register and blocks intake.
module trace_span_folder_top
   import tsf_pkg::*;
#(
   parameter int THREADS     = 8,
   parameter int STACK_DEPTH = 32,
   parameter int SPAN_RING   = 1024,
   parameter int FRAME_RING  = 512
) (
   input logic        clock,
   input logic        reset,
   tsf_req_if.sink    req_bus,
   tsf_rsp_if.source  rsp_bus
);

   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int DW = $clog2(STACK_DEPTH);
   localparam int MD = THREADS * STACK_DEPTH;
   localparam int AW = $clog2(MD);
   localparam int SW = $clog2(SPAN_RING);
   localparam int FW = $clog2(FRAME_RING);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [DEPTH_W-1:0] nest_ff   [THREADS];
   logic [SW-1:0]      cursor_ff [THREADS];
   logic [DW-1:0]      deep_ff   [THREADS];
   logic [FW-1:0]      frame_ff, frame_in;
   logic [TICK_W-1:0]  origin_ff, origin_in;
   logic [TICK_W-1:0]  latest_ff, latest_in;

   logic               accept;
   logic               thr_ok;
   logic [TW-1:0]      ti;
   logic [DEPTH_W-1:0] nest_cur, nest_new, dn;
   logic [SW-1:0]      cursor_cur, cursor_new;
   logic [DW-1:0]      deep_cur, deep_new;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   stack_entry_type    wr_data, rd_data;

   pend_type pend_ff, pend_in;

   logic               rsp_valid_ff;
   kind_type           kind_ff;
   logic [2:0]         thread_ff;
   logic [TICK_W-1:0]  start_ff, end_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [ROW_W-1:0]   max_row_ff;
   logic [DEPTH_W-1:0] open_ff;
   logic [TICK_W-1:0]  first_ff, newest_ff;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign thr_ok     = int'(req_bus.thread) < THREADS;
   assign ti         = TW'(req_bus.thread);
   assign nest_cur   = nest_ff[ti];
   assign cursor_cur = cursor_ff[ti];
   assign deep_cur   = deep_ff[ti];
   assign dn         = nest_cur - DEPTH_W'(1);

   assign wr_addr = AW'(int'(ti) * STACK_DEPTH + int'(nest_cur[DW-1:0]));
   assign rd_addr = AW'(int'(ti) * STACK_DEPTH + int'(dn[DW-1:0]));
   assign wr_data = '{tick: req_bus.tick, tag: req_bus.tag};

   always_comb begin
      nest_new   = nest_cur;
      cursor_new = cursor_cur;
      deep_new   = deep_cur;
      frame_in   = frame_ff;
      origin_in  = origin_ff;
      latest_in  = latest_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      pend_in    = '0;
      pend_in.thread = req_bus.thread;

      case (req_bus.mode)
         MODE_CLEAR_ALL: begin
            nest_new   = '0;
            cursor_new = '0;
            deep_new   = '0;
            frame_in   = '0;
            origin_in  = '0;
            latest_in  = '0;
         end
         MODE_RESET_STACKS: begin
            nest_new = '0;
         end
         MODE_BEGIN, MODE_END, MODE_FRAME: begin
            if (origin_ff == '0) begin
               origin_in = req_bus.tick;
            end
            if (req_bus.tick > latest_ff) begin
               latest_in = req_bus.tick;
            end
            if (req_bus.mode == MODE_BEGIN) begin
               if (thr_ok) begin
                  wr_en = accept && (int'(nest_cur) < STACK_DEPTH);
                  if (nest_cur != DEPTH_MAX) begin
                     nest_new = nest_cur + DEPTH_W'(1);
                  end
               end
            end else if (req_bus.mode == MODE_END) begin
               if (thr_ok && nest_cur != '0) begin
                  nest_new = dn;
                  if (int'(dn) < STACK_DEPTH) begin
                     rd_en        = accept;
                     pend_in.kind = KIND_SPAN;
                     pend_in.tick = req_bus.tick;
                     pend_in.row  = ROW_W'(dn);
                     pend_in.slot = SLOT_W'(cursor_cur);
                     cursor_new   = (cursor_cur == SW'(SPAN_RING - 1)) ? '0
                                    : cursor_cur + SW'(1);
                     if (dn > DEPTH_W'(deep_cur)) begin
                        deep_new = DW'(dn);
                     end
                  end
               end
            end else begin
               pend_in.kind = KIND_FRAME;
               pend_in.tick = req_bus.tick;
               pend_in.tag  = req_bus.tag;
               pend_in.slot = SLOT_W'(frame_ff);
               frame_in     = (frame_ff == FW'(FRAME_RING - 1)) ? '0 : frame_ff + FW'(1);
            end
         end
         default: begin
         end
      endcase

      pend_in.max_row     = thr_ok ? ROW_W'(deep_new) : '0;
      pend_in.open_depth  = thr_ok ? nest_new : '0;
      pend_in.first_tick  = origin_in;
      pend_in.newest_tick = latest_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_bus.mode == MODE_CLEAR_ALL)) begin
         for (int t = 0; t < THREADS; t++) begin
            nest_ff[t]   <= '0;
            cursor_ff[t] <= '0;
            deep_ff[t]   <= '0;
         end
      end else if (accept) begin
         if (req_bus.mode == MODE_RESET_STACKS) begin
            for (int t = 0; t < THREADS; t++) begin
               nest_ff[t] <= '0;
            end
         end else if (thr_ok) begin
            nest_ff[ti]   <= nest_new;
            cursor_ff[ti] <= cursor_new;
            deep_ff[ti]   <= deep_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         origin_ff    <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            frame_ff  <= frame_in;
            origin_ff <= origin_in;
            latest_ff <= latest_in;
         end
         if (state_ff == ST_FETCH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   // result word: for spans the stack entry joins the fold-stage results
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         kind_ff    <= pend_ff.kind;
         thread_ff  <= pend_ff.thread;
         row_ff     <= pend_ff.row;
         slot_ff    <= pend_ff.slot;
         max_row_ff <= pend_ff.max_row;
         open_ff    <= pend_ff.open_depth;
         first_ff   <= pend_ff.first_tick;
         newest_ff  <= pend_ff.newest_tick;
         if (pend_ff.kind == KIND_SPAN) begin
            start_ff <= rd_data.tick;
            end_ff   <= pend_ff.tick;
            tag_ff   <= rd_data.tag;
         end else begin
            start_ff <= pend_ff.tick;
            end_ff   <= '0;
            tag_ff   <= pend_ff.tag;
         end
      end
   end

   tsf_stack_ram #(
      .DEPTH (MD),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kind           = kind_ff;
   assign rsp_bus.out_thread     = thread_ff;
   assign rsp_bus.start_tick     = start_ff;
   assign rsp_bus.end_tick       = end_ff;
   assign rsp_bus.record_tag     = tag_ff;
   assign rsp_bus.nesting_row    = row_ff;
   assign rsp_bus.slot           = slot_ff;
   assign rsp_bus.thread_max_row = max_row_ff;
   assign rsp_bus.open_depth     = open_ff;
   assign rsp_bus.first_tick     = first_ff;
   assign rsp_bus.newest_tick    = newest_ff;

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FETCH)
      else $error("accepted word did not enter fetch");

   a_fetch_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> !req_bus.ready)
      else $error("intake open during fetch");

   a_rsp_after_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FETCH))
      else $error("result word without a fetch");

   a_frame_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_SPAN |-> end_ff == '0)
      else $error("end tick set on a non-span word");

   a_stack_ports: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("stack read and write in one cycle");

endmodule

/* tb/testbench.sv */
// Testbench for the trace span folder: directed table, long runs and random events.
`timescale 1ns / 100ps

module testbench;
   import tsf_pkg::*;

   localparam int THREADS_N    = 8;
   localparam int STACK_N      = 32;
   localparam int SPAN_RING_N  = 1024;
   localparam int FRAME_RING_N = 512;
   localparam int RANDOM_WORDS = 600;
   localparam int CHOKE_CYCLES = 400;

   // codes outside the defined set; the block must ignore them
   localparam mode_type MODE_SPARE_LO  = 3'd5;
   localparam mode_type MODE_SPARE_MID = 3'd6;
   localparam mode_type MODE_SPARE_HI  = 3'd7;

   localparam logic [TICK_W-1:0] TICK_TOP = '1;
   localparam logic [TAG_W-1:0]  TAG_TOP  = '1;

   typedef struct packed {
      mode_type          mode;
      logic [2:0]        thread;
      logic [TICK_W-1:0] tick;
      logic [TAG_W-1:0]  tag;
   } trace_ev_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         out_thread;
      logic [TICK_W-1:0]  start_tick;
      logic [TICK_W-1:0]  end_tick;
      logic [TAG_W-1:0]   record_tag;
      logic [ROW_W-1:0]   nesting_row;
      logic [SLOT_W-1:0]  slot;
      logic [ROW_W-1:0]   thread_max_row;
      logic [DEPTH_W-1:0] open_depth;
      logic [TICK_W-1:0]  first_tick;
      logic [TICK_W-1:0]  newest_tick;
   } span_rec_type;

   typedef struct {
      trace_ev_type ev;
      bit           pinned;
      span_rec_type want;
   } script_row_type;

   logic clock;
   logic reset;

   tsf_req_if req_bus ();
   tsf_rsp_if rsp_bus ();

   trace_span_folder_top #(
      .THREADS     (THREADS_N),
      .STACK_DEPTH (STACK_N),
      .SPAN_RING   (SPAN_RING_N),
      .FRAME_RING  (FRAME_RING_N)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor state
   logic [TICK_W-1:0]  zone_tick [THREADS_N][STACK_N];
   logic [TAG_W-1:0]   zone_tag [THREADS_N][STACK_N];
   logic [DEPTH_W-1:0] open_count [THREADS_N];
   logic [SLOT_W-1:0]  span_slot [THREADS_N];
   logic [ROW_W-1:0]   top_row [THREADS_N];
   logic [SLOT_W-1:0]  frame_slot;
   logic [TICK_W-1:0]  first_seen;
   logic [TICK_W-1:0]  newest_seen;

   span_rec_type due_records [$];
   script_row_type script [$];
   int mismatches;

   // typed expectation travels with the word it belongs to
   logic         pin_flag;
   span_rec_type pin_word;

   bit calm;
   bit choke_req;
   logic [TICK_W-1:0] tick_clock;
   int gen_depth [THREADS_N];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic void wipe_model();
      foreach (open_count[t]) begin
         open_count[t] = '0;
         span_slot[t]  = '0;
         top_row[t]    = '0;
      end
      frame_slot  = '0;
      first_seen  = '0;
      newest_seen = '0;
   endfunction

   function automatic span_rec_type fold_event(input trace_ev_type ev);
      span_rec_type r;
      int th;
      logic [DEPTH_W-1:0] d;
      r = '0;
      th = ev.thread;
      r.out_thread = ev.thread;
      if (ev.mode == MODE_CLEAR_ALL) begin
         wipe_model();
      end else if (ev.mode == MODE_RESET_STACKS) begin
         foreach (open_count[t]) open_count[t] = '0;
      end else if (ev.mode == MODE_BEGIN || ev.mode == MODE_END || ev.mode == MODE_FRAME) begin
         if (first_seen == '0) first_seen = ev.tick;
         if (ev.tick > newest_seen) newest_seen = ev.tick;
         d = open_count[th];
         if (ev.mode == MODE_BEGIN) begin
            // depth keeps counting past the stack, entries above it are dropped
            if (d < STACK_N) begin
               zone_tick[th][d] = ev.tick;
               zone_tag[th][d]  = ev.tag;
            end
            if (d != DEPTH_MAX) open_count[th] = d + 1'b1;
         end else if (ev.mode == MODE_END && d != '0) begin
            d = d - 1'b1;
            open_count[th] = d;
            if (d < STACK_N) begin
               r.kind        = KIND_SPAN;
               r.start_tick  = zone_tick[th][d];
               r.end_tick    = ev.tick;
               r.record_tag  = zone_tag[th][d];
               r.nesting_row = d[ROW_W-1:0];
               r.slot        = span_slot[th];
               span_slot[th] = (span_slot[th] == SPAN_RING_N - 1) ? '0 : span_slot[th] + 1'b1;
               if (d > top_row[th]) top_row[th] = d[ROW_W-1:0];
            end
         end else if (ev.mode == MODE_FRAME) begin
            r.kind       = KIND_FRAME;
            r.start_tick = ev.tick;
            r.record_tag = ev.tag;
            r.slot       = frame_slot;
            frame_slot   = (frame_slot == FRAME_RING_N - 1) ? '0 : frame_slot + 1'b1;
         end
      end
      r.thread_max_row = top_row[th];
      r.open_depth     = open_count[th];
      r.first_tick     = first_seen;
      r.newest_tick    = newest_seen;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   // scoreboard: expectation pushed on intake, compared on every result word
   always @(posedge clock) begin : watch
      span_rec_type got;
      span_rec_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.out_thread, rsp_bus.start_tick, rsp_bus.end_tick,
                    rsp_bus.record_tag, rsp_bus.nesting_row, rsp_bus.slot,
                    rsp_bus.thread_max_row, rsp_bus.open_depth, rsp_bus.first_tick,
                    rsp_bus.newest_tick};
            if (due_records.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing expected: %p", $realtime, got);
            end else begin
               want = due_records.pop_front();
               check_field("kind", 64'(want.kind), 64'(got.kind));
               check_field("out_thread", 64'(want.out_thread), 64'(got.out_thread));
               check_field("start_tick", 64'(want.start_tick), 64'(got.start_tick));
               check_field("end_tick", 64'(want.end_tick), 64'(got.end_tick));
               check_field("record_tag", 64'(want.record_tag), 64'(got.record_tag));
               check_field("nesting_row", 64'(want.nesting_row), 64'(got.nesting_row));
               check_field("slot", 64'(want.slot), 64'(got.slot));
               check_field("thread_max_row", 64'(want.thread_max_row),
                           64'(got.thread_max_row));
               check_field("open_depth", 64'(want.open_depth), 64'(got.open_depth));
               check_field("first_tick", 64'(want.first_tick), 64'(got.first_tick));
               check_field("newest_tick", 64'(want.newest_tick), 64'(got.newest_tick));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = fold_event('{req_bus.mode, req_bus.thread, req_bus.tick, req_bus.tag});
            if (pin_flag) want = pin_word;
            due_records.push_back(want);
         end
      end
   end

   // receiver: random stalls, one long hold-off when asked
   initial begin : drain_side
      bit choke_done;
      choke_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (choke_req && !choke_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
            choke_done = 1'b1;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   function automatic logic [TICK_W-1:0] next_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 14) return TICK_TOP;
      if (r < 20) return TICK_W'({$urandom(), $urandom()});
      tick_clock = tick_clock + TICK_W'($urandom_range(1, 1000));
      return tick_clock;
   endfunction

   function automatic trace_ev_type make_event(input mode_type mode, input logic [2:0] th,
                                               input logic [TICK_W-1:0] tick,
                                               input logic [TAG_W-1:0] tag);
      trace_ev_type ev;
      ev.mode   = mode;
      ev.thread = th;
      ev.tick   = tick;
      ev.tag    = tag;
      return ev;
   endfunction

   task automatic add_row(input mode_type mode, input logic [2:0] th,
                          input logic [TICK_W-1:0] tick, input logic [TAG_W-1:0] tag,
                          input bit pinned, input span_rec_type want);
      script_row_type row;
      row.ev     = make_event(mode, th, tick, tag);
      row.pinned = pinned;
      row.want   = want;
      script.push_back(row);
   endtask

   task automatic send_event(input trace_ev_type ev, input bit pinned, input span_rec_type want);
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= ev.mode;
      req_bus.thread <= ev.thread;
      req_bus.tick   <= ev.tick;
      req_bus.tag    <= ev.tag;
      pin_flag       <= pinned;
      pin_word       <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (due_records.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      int r;
      int th;
      int bias;
      mode_type mode;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= MODE_BEGIN;
      req_bus.thread <= '0;
      req_bus.tick   <= '0;
      req_bus.tag    <= '0;
      pin_flag       <= 1'b0;
      pin_word       <= '0;
      mismatches = 0;
      calm       = 1'b0;
      choke_req  = 1'b0;
      tick_clock = TICK_W'(1000);
      wipe_model();
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: orphan end after reset, nesting, extremes, ignored codes, clears
      add_row(MODE_END, 3'd3, '0, '0, 1'b1, '{out_thread: 3'd3, default: '0});
      add_row(MODE_BEGIN, 3'd0, TICK_W'(100), 32'hAAAA_0001, 1'b1,
              '{out_thread: 3'd0, open_depth: 16'd1, first_tick: TICK_W'(100),
                newest_tick: TICK_W'(100), default: '0});
      add_row(MODE_BEGIN, 3'd0, TICK_W'(200), TAG_TOP, 1'b0, '0);
      add_row(MODE_BEGIN, 3'd7, TICK_W'(300), '0, 1'b0, '0);
      add_row(MODE_END, 3'd0, TICK_W'(350), '0, 1'b0, '0);
      add_row(MODE_END, 3'd7, TICK_W'(360), TAG_TOP, 1'b0, '0);
      add_row(MODE_END, 3'd0, TICK_W'(400), '0, 1'b0, '0);
      add_row(MODE_END, 3'd0, TICK_W'(410), '0, 1'b0, '0);
      add_row(MODE_FRAME, 3'd7, TICK_TOP, TAG_TOP, 1'b0, '0);
      add_row(MODE_FRAME, 3'd7, '0, '0, 1'b0, '0);
      add_row(MODE_BEGIN, 3'd1, TICK_W'(5), 32'h0000_1234, 1'b0, '0);
      add_row(MODE_BEGIN, 3'd6, TICK_W'(77), 32'h5555_5555, 1'b0, '0);
      add_row(MODE_SPARE_LO, 3'd6, TICK_TOP, TAG_TOP, 1'b0, '0);
      add_row(MODE_SPARE_HI, 3'd2, TICK_W'(1), '0, 1'b0, '0);
      add_row(MODE_SPARE_MID, 3'd5, TICK_W'(9), 32'h8000_0000, 1'b0, '0);
      add_row(MODE_RESET_STACKS, 3'd4, TICK_W'(11), '0, 1'b0, '0);
      add_row(MODE_END, 3'd1, TICK_W'(450), '0, 1'b0, '0);
      add_row(MODE_BEGIN, 3'd1, TICK_W'(500), 32'hC0DE_0042, 1'b0, '0);
      add_row(MODE_END, 3'd1, TICK_W'(600), '0, 1'b0, '0);
      add_row(MODE_CLEAR_ALL, 3'd6, TICK_W'(123), 32'd5, 1'b1, '{out_thread: 3'd6, default: '0});
      add_row(MODE_FRAME, 3'd0, '0, '0, 1'b1, '{kind: KIND_FRAME, default: '0});
      add_row(MODE_FRAME, 3'd1, TICK_TOP, TAG_TOP, 1'b1,
              '{kind: KIND_FRAME, out_thread: 3'd1, start_tick: TICK_TOP, record_tag: TAG_TOP,
                slot: SLOT_W'(1), first_tick: TICK_TOP, newest_tick: TICK_TOP, default: '0});
      add_row(MODE_BEGIN, 3'd5, TICK_TOP, '0, 1'b0, '0);
      add_row(MODE_END, 3'd5, TICK_TOP, TAG_TOP, 1'b0, '0);
      foreach (script[i]) send_event(script[i].ev, script[i].pinned, script[i].want);
      wait_drained();

      // fill one stack past its top, then unwind through the deep ends and an orphan
      for (int i = 0; i < STACK_N + 1; i++)
         send_event(make_event(MODE_BEGIN, 3'd4, next_tick(), $urandom()), 1'b0, '0);
      for (int i = 0; i < STACK_N + 2; i++)
         send_event(make_event(MODE_END, 3'd4, next_tick(), $urandom()), 1'b0, '0);
      wait_drained();

      // wrap the frame ring
      for (int i = 0; i < FRAME_RING_N + 6; i++)
         send_event(make_event(MODE_FRAME, 3'($urandom_range(0, 7)), next_tick(), $urandom()),
                    1'b0, '0);
      wait_drained();

      // random traffic, mostly nested begin/end with frames and the odd clear
      foreach (gen_depth[t]) gen_depth[t] = 0;
      choke_req = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 350 && i < 500);
         if (i == 300 || $urandom_range(0, 199) == 0) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (due_records.size() != 0);
         end
         r  = $urandom_range(0, 999);
         th = $urandom_range(0, THREADS_N - 1);
         if (r < 5) begin
            mode = MODE_CLEAR_ALL;
         end else if (r < 15) begin
            mode = MODE_RESET_STACKS;
         end else if (r < 25) begin
            mode = mode_type'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end else if (r < 105) begin
            mode = MODE_FRAME;
         end else begin
            bias = (gen_depth[th] == 0) ? 75 : (gen_depth[th] >= 40) ? 35 : 56;
            mode = ($urandom_range(0, 99) < bias) ? MODE_BEGIN : MODE_END;
         end
         if (mode == MODE_CLEAR_ALL || mode == MODE_RESET_STACKS)
            foreach (gen_depth[t]) gen_depth[t] = 0;
         else if (mode == MODE_BEGIN && gen_depth[th] < int'(DEPTH_MAX))
            gen_depth[th]++;
         else if (mode == MODE_END && gen_depth[th] > 0)
            gen_depth[th]--;
         send_event(make_event(mode, 3'(th), next_tick(), $urandom()), 1'b0, '0);
      end
      calm = 1'b0;
      wait_drained();

      if (mismatches == 0 && due_records.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tsf_pkg.sv
rtl/tsf_if.sv
rtl/tsf_stack_ram.sv
rtl/trace_span_folder_top.sv
tb/testbench.sv
